// ===== sv/bbse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbse_pkg
// Shared types and constants of the bicubic B-spline surface evaluator.
// ----------------------------------------------------------------------------
package bbse_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_S = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_T = 2'd1;
    localparam logic [1:0] CFG_INV_S    = 2'd2;
    localparam logic [1:0] CFG_INV_T    = 2'd3;

    // item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // accumulator width: sixteen terms of 30-bit weight times 32-bit point
    localparam int SUM_W = 67;

    // floor(x / 3) = (x * RECIP3) >> 33 for any x below 2^32
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    // basis weight, unsigned Q0.30
    typedef logic [30:0] t_weight;
    typedef t_weight [3:0] t_wvec;

    // query sequencer states
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MAG  = 12'b0000_0000_0010,
        S_MLO  = 12'b0000_0000_0100,
        S_MHI  = 12'b0000_0000_1000,
        S_POS  = 12'b0000_0001_0000,
        S_CELL = 12'b0000_0010_0000,
        S_SQ   = 12'b0000_0100_0000,
        S_CU   = 12'b0000_1000_0000,
        S_NUM  = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_MAC  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

endpackage

// ===== sv/bicubic_bspline_surface_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bspline_surface_eval
// Uniform bicubic B-spline surface over a grid of control points.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one control point. A query item (tuser 1)
// runs twelve steps of mapping and basis evaluation per axis through a
// narrow multiplier path, then the sixteen neighborhood points stream out of
// the single grid read port into a four-stage multiply-accumulate. A query
// whose neighborhood leaves the grid skips the multiply-accumulate and
// finishes with height 0 and tuser 1. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// Grid entries must be written before a query reads them.
// ----------------------------------------------------------------------------
module bicubic_bspline_surface_eval
    import bbse_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    // input items
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // grid_row[5:0], grid_col[11:6], point_value[43:12], s_coord[75:44],
    // t_coord[107:76], zero pad
    input  logic [111:0] i_s_axis_tdata,
    // func[0]
    input  logic         i_s_axis_tuser,
    // results
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // height[31:0]
    output logic [31:0]  o_m_axis_tdata,
    // out_of_bounds[0]
    output logic         o_m_axis_tuser
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int AW = $clog2(GRID_ROWS * GRID_COLS);

    // configuration registers
    logic [31:0] r_origin_s, r_origin_t, r_inv_s, r_inv_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_s <= '0;
            r_origin_t <= '0;
            r_inv_s    <= 32'd65536;
            r_inv_t    <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_S: r_origin_s <= i_cfg_data;
                CFG_ORIGIN_T: r_origin_t <= i_cfg_data;
                CFG_INV_S:    r_inv_s    <= i_cfg_data;
                CFG_INV_T:    r_inv_t    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // input fields
    logic [5:0]  in_row, in_col;
    logic [31:0] in_value, in_s, in_t;
    logic        in_acc;

    assign in_row   = i_s_axis_tdata[5:0];
    assign in_col   = i_s_axis_tdata[11:6];
    assign in_value = i_s_axis_tdata[43:12];
    assign in_s     = i_s_axis_tdata[75:44];
    assign in_t     = i_s_axis_tdata[107:76];

    t_state r_state;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // control point write goes straight to the grid memory
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    assign wr_en   = in_acc && (i_s_axis_tuser == FUNC_WRITE)
                     && (32'(in_row) < 32'(GRID_ROWS))
                     && (32'(in_col) < 32'(GRID_COLS));
    assign wr_addr = AW'(32'(in_row) * GRID_COLS + 32'(in_col));

    // sequencer registers
    logic               r_axis;
    logic [1:0]         r_k;
    logic signed [32:0] r_d_s, r_d_t;
    logic               r_neg;
    logic [32:0]        r_mag;
    logic [47:0]        r_pp_lo;
    logic [48:0]        r_pp_hi;
    logic [64:0]        r_prod;
    logic [15:0]        r_u;
    logic [31:0]        r_u2;
    logic [47:0]        r_u3;
    logic [31:0]        r_x [4];
    t_wvec              r_ws, r_wt;
    logic [CW-1:0]      r_base_s;
    logic [RW-1:0]      r_base_t;
    logic               r_oob;
    logic               r_mac_start;
    logic signed [SUM_W-1:0] r_sum;
    logic               r_m_valid;
    logic [31:0]        r_m_height;
    logic               r_m_oob;

    // axis selection
    logic signed [32:0] d_sel;
    logic [31:0]        inv_sel;
    assign d_sel   = r_axis ? r_d_t : r_d_s;
    assign inv_sel = r_axis ? r_inv_t : r_inv_s;

    // cell and fraction from the scaled product
    logic signed [65:0] neg_prod;
    logic signed [49:0] posv;
    logic signed [33:0] cell_no;
    logic signed [33:0] cell_lim;
    logic               axis_oob;
    logic [33:0]        cell_m1;

    assign neg_prod = -$signed({1'b0, r_prod});
    assign posv     = r_neg ? 50'(neg_prod >>> 16) : $signed({1'b0, r_prod[64:16]});
    assign cell_no  = posv[49:16];
    assign cell_lim = r_axis ? $signed(34'(GRID_ROWS - 3)) : $signed(34'(GRID_COLS - 3));
    assign axis_oob = (cell_no < 34'sd1) || (cell_no > cell_lim);
    assign cell_m1  = cell_no - 34'sd1;

    // basis numerators, exact and non-negative, scaled by 2^48
    logic [52:0] u3w, u2d, ud2, d3;
    logic [52:0] num [4];
    logic [52:0] numr [4];
    assign u3w = 53'(r_u3);
    assign u2d = 53'(r_u2) << 16;
    assign ud2 = 53'(r_u) << 32;
    assign d3  = 53'd1 << 48;

    always_comb begin
        num[0] = d3 - 53'd3 * ud2 + 53'd3 * u2d - u3w;
        num[1] = 53'd3 * u3w - 53'd6 * u2d + 53'd4 * d3;
        num[2] = d3 + 53'd3 * ud2 + 53'd3 * u2d - 53'd3 * u3w;
        num[3] = u3w;
        for (int i = 0; i < 4; i++) begin
            numr[i] = num[i] + (53'd3 << 18);
        end
    end

    // divide by three via reciprocal
    logic [63:0] div_prod;
    assign div_prod = 64'(r_x[r_k]) * 64'(RECIP3);

    // final rounding and saturation
    logic signed [SUM_W-1:0] sum_rnd;
    logic signed [36:0]      h_wide;
    logic [31:0]             h_sat;
    assign sum_rnd = r_sum + (SUM_W'(1) << 29);
    assign h_wide  = sum_rnd[SUM_W-1:30];
    always_comb begin
        if (h_wide > 37'sh0_7FFF_FFFF) begin
            h_sat = 32'h7FFF_FFFF;
        end else if (h_wide < -37'sh0_8000_0000) begin
            h_sat = 32'h8000_0000;
        end else begin
            h_sat = h_wide[31:0];
        end
    end

    logic                    mac_done;
    logic signed [SUM_W-1:0] mac_sum;

    // query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_k         <= '0;
            r_oob       <= 1'b0;
            r_mac_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_mac_start <= 1'b0;
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_s_axis_tuser == FUNC_EVAL)) begin
                        r_d_s   <= $signed({in_s[31], in_s})
                                   - $signed({r_origin_s[31], r_origin_s});
                        r_d_t   <= $signed({in_t[31], in_t})
                                   - $signed({r_origin_t[31], r_origin_t});
                        r_axis  <= 1'b0;
                        r_oob   <= 1'b0;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_neg   <= d_sel[32];
                    r_mag   <= d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_pp_lo <= 48'(r_mag[15:0]) * 48'(inv_sel);
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_pp_hi <= 49'(r_mag[32:16]) * 49'(inv_sel);
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_prod  <= {r_pp_hi, 16'd0} + 65'(r_pp_lo);
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_oob <= r_oob | axis_oob;
                    r_u   <= posv[15:0];
                    if (r_axis) begin
                        r_base_t <= cell_m1[RW-1:0];
                    end else begin
                        r_base_s <= cell_m1[CW-1:0];
                    end
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_u2    <= 32'(r_u) * 32'(r_u);
                    r_state <= S_CU;
                end
                S_CU: begin
                    r_u3    <= 48'(r_u2) * 48'(r_u);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    for (int i = 0; i < 4; i++) begin
                        r_x[i] <= numr[i][50:19];
                    end
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_axis) begin
                        r_wt[r_k] <= div_prod[63:33];
                    end else begin
                        r_ws[r_k] <= div_prod[63:33];
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_MAG;
                        end else if (r_oob) begin
                            r_state <= S_FIN;
                        end else begin
                            r_mac_start <= 1'b1;
                            r_state     <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_sum   <= mac_sum;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_height <= r_oob ? 32'd0 : h_sat;
                        r_m_oob    <= r_oob;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bbse_mac #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RW        (RW),
        .CW        (CW),
        .AW        (AW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_value),
        .i_start   (r_mac_start),
        .i_base_s  (r_base_s),
        .i_base_t  (r_base_t),
        .i_ws      (r_ws),
        .i_wt      (r_wt),
        .o_done    (mac_done),
        .o_sum     (mac_sum)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_height;
    assign o_m_axis_tuser  = r_m_oob;

endmodule

// ===== sv/bbse_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbse_mac
// Control grid memory and the 4x4 weighted sum: one grid read per cycle,
// weight product, rounding, point product and accumulation in a pipeline.
// ----------------------------------------------------------------------------
module bbse_mac
    import bbse_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64,
    parameter int RW        = $clog2(GRID_ROWS),
    parameter int CW        = $clog2(GRID_COLS),
    parameter int AW        = $clog2(GRID_ROWS * GRID_COLS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [31:0]             i_wr_data,
    input  logic                    i_start,
    input  logic [CW-1:0]           i_base_s,
    input  logic [RW-1:0]           i_base_t,
    input  t_wvec                   i_ws,
    input  t_wvec                   i_wt,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_sum
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    logic        r_issue;
    logic [3:0]  r_idx;
    logic        r_v1, r_v2, r_v3;
    logic        r_l1, r_l2, r_l3;
    logic        r_done;
    logic [61:0] r_wp;
    logic [31:0] r_wkl;
    logic signed [31:0] r_p;
    logic signed [64:0] r_term;
    logic signed [SUM_W-1:0] r_sum;

    logic [1:0]    k_s, l_t;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [AW-1:0] rd_addr;
    logic [61:0]   wp_rnd;

    // neighborhood address: column step k, row step l
    assign k_s     = r_idx[3:2];
    assign l_t     = r_idx[1:0];
    assign rd_row  = i_base_t + RW'(l_t);
    assign rd_col  = i_base_s + CW'(k_s);
    assign rd_addr = AW'(32'(rd_row) * GRID_COLS + 32'(rd_col));
    assign wp_rnd  = r_wp + (62'd1 << 29);

    // grid memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // issue counter and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_l1    <= 1'b0;
            r_l2    <= 1'b0;
            r_l3    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
                r_idx   <= '0;
            end else if (r_issue) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == 4'd15) begin
                    r_issue <= 1'b0;
                end
            end
            r_v1   <= r_issue;
            r_l1   <= r_issue && (r_idx == 4'd15);
            r_v2   <= r_v1;
            r_l2   <= r_l1;
            r_v3   <= r_v2;
            r_l3   <= r_l2;
            r_done <= r_v3 && r_l3;
        end
    end

    // datapath: weight product, round, point product, accumulate
    always_ff @(posedge i_clk) begin
        r_wp   <= 62'(i_ws[k_s]) * 62'(i_wt[l_t]);
        r_wkl  <= wp_rnd[61:30];
        r_p    <= r_rdata;
        r_term <= $signed({1'b0, r_wkl}) * r_p;
        if (i_start) begin
            r_sum <= '0;
        end else if (r_v3) begin
            r_sum <= r_sum + SUM_W'(r_term);
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule
